/* rtl/source_garbage_timeout_table_assert.svh */
// Assertion macros for the source garbage timeout table
`ifndef SOURCE_GARBAGE_TIMEOUT_TABLE_ASSERT_SVH
`define SOURCE_GARBAGE_TIMEOUT_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SGT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SGT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SGT_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SGT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/sgt_pkg.sv */
`default_nettype none
package sgt_pkg;
    localparam int TableEntries = 256;
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [2:0] CFG_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_GUARD = 3'd1;
    localparam logic [2:0] CFG_LIMIT = 3'd2;
    localparam logic [2:0] CFG_FULL_STALE = 3'd3;
    localparam logic [2:0] CFG_MAX_AGE = 3'd4;
    // entry record: last_seen, total, block_until, strikes, source
    localparam int RecW = 48 + 16 + 48 + 3 + 64;
    typedef struct packed {
        logic [47:0] last_seen;
        logic [15:0] total;
        logic [47:0] block_until;
        logic [2:0]  strikes;
        logic [63:0] source;
    } t_rec;
    // commands controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic rd;        // issue read at scan index
        logic eval;      // evaluate read data
        logic commit;    // write entry for report
        logic done;      // result ready
    } t_cmd;
    // status datapath -> controller
    typedef struct packed {
        logic last_idx;
        logic hit;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/sgt_ram.sv */
`default_nettype none
module sgt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/sgt_ctrl.sv */
`default_nettype none
module sgt_ctrl import sgt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_out_taken,
    input  t_sts      i_sts,
    output logic      o_idle,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_COMMIT, S_OUT} t_state;
    t_state r_state;
    logic r_first;

    // walk every slot: read one per cycle, evaluate the previous one
    always_comb begin
        o_cmd = '0;
        o_idle = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                o_cmd.rd = i_start;
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                o_cmd.eval = !r_first;
            end
            S_LAST: o_cmd.eval = 1'b1;
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                o_cmd.done = 1'b1;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= S_SCAN;
                    r_first <= 1'b1;
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    if (i_sts.last_idx) r_state <= S_LAST;
                end
                S_LAST: r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_OUT;
                S_OUT: if (i_out_taken) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/sgt_dp.sv */
`default_nettype none
module sgt_dp import sgt_pkg::*; #(
    parameter int Entries = TableEntries
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  t_cmd              i_cmd,
    input  wire logic [1:0]   i_op,
    input  wire logic [63:0]  i_id,
    input  wire logic [47:0]  i_now,
    input  wire logic [15:0]  i_timeout,
    input  wire logic [15:0]  i_guard,
    input  wire logic [2:0]   i_limit,
    input  wire logic [31:0]  i_full_stale,
    input  wire logic [31:0]  i_max_age,
    output t_sts              o_sts,
    output logic              o_blocked,
    output logic              o_counted,
    output logic              o_started,
    output logic [15:0]       o_total,
    output logic              o_full,
    output logic [$clog2(Entries+1)-1:0] o_used
);
    localparam int AW = $clog2(Entries);
    localparam int CW = $clog2(Entries+1);

    logic [1:0]  r_op;
    logic [63:0] r_id;
    logic [47:0] r_now;
    logic [AW-1:0] r_idx, r_eidx;
    logic r_sweep_full;
    logic r_hit, r_free_found;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    t_rec r_hit_rec;
    logic [CW-1:0] r_occ;
    logic [Entries-1:0] r_valid;
    logic r_blocked, r_counted, r_started;
    logic [15:0] r_total;

    t_rec w_rd;
    logic [RecW-1:0] w_rdata;
    t_rec n_rec;
    logic w_we;
    logic [AW-1:0] w_waddr;
    logic w_ev_valid, w_match, w_stale;
    logic [48:0] w_sum_full, w_sum_age, w_end;
    logic [48:0] w_guard_sum;
    logic w_do_count;
    logic [2:0] w_strk;
    logic w_have;

    assign w_rd = t_rec'(w_rdata);
    assign o_sts.last_idx = (r_idx == AW'(Entries-1));
    assign o_sts.hit = r_hit;

    // evaluation of the slot read last cycle
    assign w_ev_valid = r_valid[r_eidx];
    assign w_match = w_ev_valid && (w_rd.source == r_id);
    assign w_sum_full = {1'b0, w_rd.last_seen} + {17'd0, i_full_stale};
    assign w_sum_age = {1'b0, w_rd.last_seen} + {17'd0, i_max_age};
    assign w_stale = w_ev_valid &&
        ((r_sweep_full && w_sum_full < {1'b0, r_now}) || ({1'b0, r_now} > w_sum_age));

    // strike rule on found or new entry
    assign w_have = r_hit || (r_free_found && r_occ < CW'(Entries));
    always_comb begin
        n_rec = r_hit_rec;
        if (!r_hit) begin
            n_rec.source = r_id;
            n_rec.strikes = '0;
            n_rec.block_until = '0;
            n_rec.total = '0;
            n_rec.last_seen = r_now;
        end
        w_guard_sum = {1'b0, r_now} + {33'd0, i_guard};
        w_do_count = w_guard_sum > {1'b0, n_rec.block_until};
        w_end = {1'b0, r_now} + {33'd0, i_timeout};
        w_strk = (n_rec.strikes == 3'd7) ? 3'd7 : n_rec.strikes + 3'd1;
        if (w_do_count) begin
            n_rec.last_seen = r_now;
            n_rec.strikes = w_strk;
            if (w_strk >= i_limit) begin
                if (n_rec.total != 16'hFFFF) n_rec.total = n_rec.total + 16'd1;
                n_rec.block_until = w_end[48] ? 48'hFFFF_FFFF_FFFF : w_end[47:0];
                n_rec.strikes = '0;
            end
        end
    end

    assign w_we = i_cmd.commit && r_op == OP_REPORT && w_have;
    assign w_waddr = r_hit ? r_hit_idx : r_free_idx;

    sgt_ram #(.Width(RecW), .Depth(Entries)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(RecW'(n_rec)),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_id;
            r_now <= i_now;
            r_sweep_full <= (r_occ >= CW'(Entries));
            r_hit <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.rd) begin
            r_eidx <= r_idx;
        end
        if (i_cmd.eval && r_op != OP_SWEEP) begin
            if (w_match && !r_hit) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_eidx;
                r_hit_rec <= w_rd;
            end
            if (!w_ev_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx <= r_eidx;
            end
        end
        if (i_cmd.done) begin
            r_blocked <= r_op == OP_CHECK && r_hit && r_now < r_hit_rec.block_until;
            r_counted <= r_op == OP_REPORT && w_have && w_do_count;
            r_started <= r_op == OP_REPORT && w_have && w_do_count && w_strk >= i_limit;
            r_total <= (r_op == OP_REPORT && w_have) ? n_rec.total : 16'd0;
        end
    end

    // control: scan index, valid bits, occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_valid <= '0;
            r_occ <= '0;
        end else begin
            if (i_cmd.load) r_idx <= '0;
            else if (i_cmd.rd) r_idx <= r_idx + AW'(1);
            if (i_cmd.eval && r_op == OP_SWEEP && w_stale) begin
                r_valid[r_eidx] <= 1'b0;
                r_occ <= r_occ - CW'(1);
            end
            if (w_we && !r_hit) begin
                r_valid[w_waddr] <= 1'b1;
                r_occ <= r_occ + CW'(1);
            end
        end
    end

    assign o_blocked = r_blocked;
    assign o_counted = r_counted;
    assign o_started = r_started;
    assign o_total = r_total;
    assign o_full = r_occ >= CW'(Entries);
    assign o_used = r_occ;
endmodule
`default_nettype wire

/* rtl/source_garbage_timeout_table.sv */
// Source garbage timeout table.
// Input stream (s_axis): one operation per transfer: check, report bad
// message, or expiry sweep, keyed by a 64-bit source id and the time now.
// Output stream (m_axis): one result per operation.
// Config port: i_cfg_we writes register i_cfg_addr with i_cfg_wdata;
// write only while idle.
// Every operation walks all TABLE_ENTRIES slots of the entry RAM, one read
// per cycle, then evaluates the last slot, writes a reported entry and shows
// the result. The block is idle again in the cycle after the result transfer
// and takes no new item before that.
// Valid bits sit in flip-flops and are cleared by reset: the table starts
// empty and no clearing pass is needed. Registers return to their defaults.
// While the receiver stalls the result holds and no new item is accepted.
`default_nettype none
module source_garbage_timeout_table import sgt_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntries
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] source_id, [111:64] now_ms, [119:112] zero
    input  wire logic [119:0] s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] is_blocked, [1] strike_counted, [2] block_started,
    // [18:3] blocks_so_far, [19] table_full, [28:20] used_entries, [31:29] zero
    output logic [31:0]       m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_wdata
);
    localparam int CW = $clog2(TABLE_ENTRIES+1);
    logic [15:0] r_timeout, r_guard;
    logic [2:0]  r_limit;
    logic [31:0] r_full_stale, r_max_age;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle, w_blk, w_cnt, w_st, w_full;
    logic [15:0] w_tot;
    logic [CW-1:0] w_used;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd12000;
            r_guard <= 16'd8000;
            r_limit <= 3'd6;
            r_full_stale <= 32'd1200000;
            r_max_age <= 32'd86400000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata[15:0];
                CFG_GUARD: r_guard <= i_cfg_wdata[15:0];
                CFG_LIMIT: r_limit <= i_cfg_wdata[2:0];
                CFG_FULL_STALE: r_full_stale <= i_cfg_wdata;
                CFG_MAX_AGE: r_max_age <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = w_idle;

    sgt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && w_idle),
        .i_out_taken(m_axis_tready),
        .i_sts(w_sts), .o_idle(w_idle), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    sgt_dp #(.Entries(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_op(s_axis_tuser), .i_id(s_axis_tdata[63:0]), .i_now(s_axis_tdata[111:64]),
        .i_timeout(r_timeout), .i_guard(r_guard), .i_limit(r_limit),
        .i_full_stale(r_full_stale), .i_max_age(r_max_age),
        .o_sts(w_sts), .o_blocked(w_blk), .o_counted(w_cnt), .o_started(w_st),
        .o_total(w_tot), .o_full(w_full), .o_used(w_used)
    );

    assign m_axis_tdata = {3'd0, 9'(w_used), w_full, w_tot, w_st, w_cnt, w_blk};

    `include "source_garbage_timeout_table_assert.svh"
    `SGT_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `SGT_ASSERT_IMPL(a_start_needs_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1])
    `SGT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
`default_nettype wire

/* tb/sv/source_garbage_timeout_table_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module source_garbage_timeout_table_tb;
    import sgt_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ENTRIES = 256;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;

    // packed from the top bit of the result word down
    typedef struct packed {
        logic [8:0]  used_entries;
        logic        table_full;
        logic [15:0] blocks_so_far;
        logic        block_started;
        logic        strike_counted;
        logic        is_blocked;
    } t_verdict;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [31:0]  i_cfg_wdata;

    source_garbage_timeout_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // shadow of the source table
    logic        tbl_valid [ENTRIES];
    logic [63:0] tbl_source [ENTRIES];
    logic [2:0]  tbl_strikes [ENTRIES];
    logic [47:0] tbl_block_until [ENTRIES];
    logic [15:0] tbl_block_total [ENTRIES];
    logic [47:0] tbl_last_seen [ENTRIES];
    int          tbl_used;

    // shadow of the registers
    logic [15:0] reg_timeout;
    logic [15:0] reg_guard;
    logic [2:0]  reg_limit;
    logic [31:0] reg_full_stale;
    logic [31:0] reg_max_age;

    t_verdict    pending_verdicts[$];
    int          mismatches;
    bit          no_idle;
    bit          timed_out;
    logic [47:0] clock_ms;
    logic [63:0] id_pool [24];

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int find_source(logic [63:0] id);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_source[i] == id) return i;
        return -1;
    endfunction

    // next table state and the verdict for one accepted operation
    function automatic t_verdict predict_verdict(logic [1:0] op, logic [63:0] id,
                                                 logic [47:0] now);
        t_verdict v;
        int s;
        bit full;
        logic [63:0] sum;
        v = '0;
        case (op)
            OP_CHECK: begin
                s = find_source(id);
                if (s >= 0 && now < tbl_block_until[s]) v.is_blocked = 1'b1;
            end
            OP_REPORT: begin
                s = find_source(id);
                if (s < 0 && tbl_used < ENTRIES) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!tbl_valid[i]) begin
                            s = i;
                            break;
                        end
                    end
                    tbl_valid[s] = 1'b1;
                    tbl_source[s] = id;
                    tbl_strikes[s] = '0;
                    tbl_block_until[s] = '0;
                    tbl_block_total[s] = '0;
                    tbl_last_seen[s] = now;
                    tbl_used++;
                end
                if (s >= 0) begin
                    if (64'(now) + 64'(reg_guard) > 64'(tbl_block_until[s])) begin
                        v.strike_counted = 1'b1;
                        tbl_last_seen[s] = now;
                        if (tbl_strikes[s] != 3'd7) tbl_strikes[s]++;
                        if (tbl_strikes[s] >= reg_limit) begin
                            v.block_started = 1'b1;
                            if (tbl_block_total[s] != 16'hFFFF) tbl_block_total[s]++;
                            sum = 64'(now) + 64'(reg_timeout);
                            tbl_block_until[s] = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[47:0];
                            tbl_strikes[s] = '0;
                        end
                    end
                    v.blocks_so_far = tbl_block_total[s];
                end
            end
            OP_SWEEP: begin
                // fullness is decided once, before any removal
                full = (tbl_used >= ENTRIES);
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] &&
                        ((full && 64'(tbl_last_seen[i]) + 64'(reg_full_stale) < 64'(now)) ||
                         64'(now) > 64'(tbl_last_seen[i]) + 64'(reg_max_age))) begin
                        tbl_valid[i] = 1'b0;
                        tbl_used--;
                    end
                end
            end
            default: ;
        endcase
        v.table_full = (tbl_used >= ENTRIES);
        v.used_entries = 9'(tbl_used);
        return v;
    endfunction

    // one operation, left valid after its transfer until the next call
    task automatic send_op(logic [1:0] op, logic [63:0] id, logic [47:0] now);
        if (!no_idle && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {8'd0, now, id};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_verdicts.push_back(predict_verdict(op, id, now));
    endtask

    // stop sending and wait until every result is in and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIMEOUT:    reg_timeout = value[15:0];
            CFG_GUARD:      reg_guard = value[15:0];
            CFG_LIMIT:      reg_limit = value[2:0];
            CFG_FULL_STALE: reg_full_stale = value;
            CFG_MAX_AGE:    reg_max_age = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] tmo, logic [15:0] grd, logic [2:0] lim,
                            logic [31:0] stale, logic [31:0] age);
        drain();
        write_reg(CFG_TIMEOUT, 32'(tmo));
        write_reg(CFG_GUARD, 32'(grd));
        write_reg(CFG_LIMIT, 32'(lim));
        write_reg(CFG_FULL_STALE, stale);
        write_reg(CFG_MAX_AGE, age);
    endtask

    // strikes up to a block with reset registers, guard window, unused opcode
    task automatic test_strike_and_block();
        logic [63:0] id;
        id = 64'hFFFF_FFFF_FFFF_FFFF;
        clock_ms = 48'd1000;
        send_op(OP_CHECK, id, clock_ms);
        for (int k = 0; k < 6; k++) send_op(OP_REPORT, id, clock_ms);
        send_op(OP_CHECK, id, clock_ms + 48'd11999);
        send_op(OP_REPORT, id, clock_ms + 48'd100);      // inside guard window
        send_op(OP_REPORT, id, clock_ms + 48'd4001);     // just outside it
        send_op(OP_CHECK, id, clock_ms + 48'd12000);     // block over
        send_op(OP_UNUSED, id, clock_ms);
        send_op(OP_REPORT, 64'd0, clock_ms);
        send_op(OP_SWEEP, 64'd0, clock_ms);
        clock_ms = clock_ms + 48'd20000;
    endtask

    // limit zero and saturating block end at the top of the time range
    task automatic test_limit_and_saturation();
        set_regs(16'hFFFF, 16'hFFFF, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_REPORT, 64'h8000_0000_0000_0001, TIME_MAX - 48'd10);
        send_op(OP_REPORT, 64'h8000_0000_0000_0001, TIME_MAX);
        send_op(OP_CHECK, 64'h8000_0000_0000_0001, TIME_MAX - 48'd1);
        send_op(OP_SWEEP, 64'd0, TIME_MAX);
        set_regs(16'd1, 16'd0, 3'd1, 32'd0, 32'd0);
        send_op(OP_REPORT, 64'h5555_AAAA_5555_AAAA, clock_ms);
        send_op(OP_REPORT, 64'h5555_AAAA_5555_AAAA, clock_ms);
        send_op(OP_SWEEP, 64'd0, clock_ms + 48'd1);      // age zero clears older entries
    endtask

    // fill every slot, report when full, then a sweep in the full state
    task automatic test_full_table();
        set_regs(16'd12000, 16'd8000, 3'd7, 32'd50, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        for (int k = 0; k < ENTRIES; k++) begin
            send_op(OP_REPORT, {$urandom, $urandom}, clock_ms);
            clock_ms = clock_ms + 48'(k % 2);
        end
        no_idle = 1'b0;
        send_op(OP_REPORT, {$urandom, $urandom}, clock_ms);
        send_op(OP_CHECK, {$urandom, $urandom}, clock_ms);
        send_op(OP_SWEEP, 64'd0, clock_ms + 48'd60);
        send_op(OP_SWEEP, 64'd0, clock_ms + 48'd200);
        clock_ms = clock_ms + 48'd300;
    endtask

    // random operations on a small pool of sources under one register setting
    task automatic test_random_phase(int count);
        int r;
        logic [1:0] op;
        logic [63:0] id;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) op = OP_REPORT;
            else if (r < 85) op = OP_CHECK;
            else if (r < 95) op = OP_SWEEP;
            else op = OP_UNUSED;
            id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : id_pool[$urandom_range(0, 23)];
            if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + 48'($urandom_range(0, 200000));
            else clock_ms = clock_ms + 48'($urandom_range(0, 1500));
            send_op(op, id, clock_ms);
        end
    endtask

    // checker
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_verdict'(m_axis_tdata[28:0]);
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want || m_axis_tdata[31:29] !== 3'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: blk %b/%b cnt %b/%b st %b/%b tot %0d/%0d",
                                  " full %b/%b used %0d/%0d"},
                                 want.is_blocked, got.is_blocked,
                                 want.strike_counted, got.strike_counted,
                                 want.block_started, got.block_started,
                                 want.blocks_so_far, got.blocks_so_far,
                                 want.table_full, got.table_full,
                                 want.used_entries, got.used_entries);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 21);

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[source_garbage_timeout_table] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        mismatches = 0;
        no_idle = 1'b0;
        timed_out = 1'b0;
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        tbl_used = 0;
        reg_timeout = 16'd12000;
        reg_guard = 16'd8000;
        reg_limit = 3'd6;
        reg_full_stale = 32'd1200000;
        reg_max_age = 32'd86400000;
        for (int i = 0; i < 24; i++) id_pool[i] = {$urandom, $urandom};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_strike_and_block();
        test_limit_and_saturation();
        test_full_table();
        set_regs(16'd1, 16'd0, 3'd0, 32'hFFFF_FFFF, 32'd0);
        test_random_phase(40);
        set_regs(16'd12000, 16'd8000, 3'd6, 32'd1200000, 32'd86400000);
        test_random_phase(220);
        set_regs(16'd3000, 16'd1000, 3'd3, 32'd2000, 32'd20000);
        no_idle = 1'b1;
        test_random_phase(200);
        no_idle = 1'b0;
        set_regs(16'hFFFF, 16'hFFFF, 3'd7, 32'd0, 32'd5000);
        test_random_phase(220);
        set_regs(16'd500, 16'd0, 3'd1, 32'd100, 32'hFFFF_FFFF);
        test_random_phase(220);
        set_regs(16'd8000, 16'd2000, 3'd2, 32'd10000, 32'd60000);
        test_random_phase(180);
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("[source_garbage_timeout_table] OK");
        else
            $display("[source_garbage_timeout_table] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* source_garbage_timeout_table.f */
+incdir+rtl
rtl/sgt_pkg.sv
rtl/sgt_ram.sv
rtl/sgt_ctrl.sv
rtl/sgt_dp.sv
rtl/source_garbage_timeout_table.sv
tb/sv/source_garbage_timeout_table_tb.sv
